// ===== src/ftsi_pkg.sv =====
`default_nettype none
package ftsi_pkg;

    localparam int MAX_VARS  = 8;
    localparam int MAX_RULES = 16;
    localparam int FRAC_BITS = 16;

    localparam int VAR_W    = 3;
    localparam int RULE_W   = 4;
    localparam int CNT_W    = 5;
    localparam int VAL_W    = 32;
    localparam int RADDR_W  = $clog2(MAX_VARS * MAX_RULES);
    localparam int MU_W     = FRAC_BITS + 1;
    localparam int PROD_W   = MU_W + 1 + VAL_W;
    localparam int WSUM_W   = PROD_W + $clog2(MAX_RULES) + 1;
    localparam int MSUM_W   = MU_W + $clog2(MAX_RULES) + 1;
    localparam int ACC_W    = 48;

    // operation codes
    localparam logic [1:0] OP_WRITE_RULE = 2'd0;
    localparam logic [1:0] OP_SET_VAR    = 2'd1;
    localparam logic [1:0] OP_SAMPLE     = 2'd2;

    // register addresses
    localparam logic [1:0] ADDR_GLOBAL_BIAS = 2'd0;

    // one stored rule
    typedef struct packed {
        logic signed [VAL_W-1:0] left;
        logic signed [VAL_W-1:0] peak;
        logic signed [VAL_W-1:0] right;
        logic signed [VAL_W-1:0] theta;
    } t_rule;

endpackage
`default_nettype wire

// ===== src/ftsi_rule_mem.sv =====
`default_nettype none
module ftsi_rule_mem (
    input  wire                           i_clk,
    input  wire                           i_we,
    input  wire  [ftsi_pkg::RADDR_W-1:0]  i_waddr,
    input  wire  ftsi_pkg::t_rule         i_wdata,
    input  wire  [ftsi_pkg::RADDR_W-1:0]  i_raddr,
    output ftsi_pkg::t_rule               o_rdata
);
    import ftsi_pkg::*;

    t_rule r_mem [MAX_VARS*MAX_RULES];
    t_rule r_q;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule
`default_nettype wire

// ===== src/fuzzy_ts_univariate_sum_inference_unit.sv =====
// Sum of per-variable zero-order Takagi-Sugeno fuzzy models, triangular sets.
// Input channel (i_in_valid / o_in_stall) carries one request per item:
//   write rule  - stores one rule of a variable
//   set var     - sets rule count (clipped to 16) and bias
//   sample      - evaluates one variable and adds it, less its bias, to the vector sum
// A sample with i_last_var set produces one result on the output channel
// (o_out_valid / i_out_stall): estimate plus global bias, clipped to Q16.16,
// with o_saturated marking a clip. The vector sum is then cleared.
// Sample steps: a rule whose triangle holds the sample runs a 16-step serial
// divide, a rule that misses skips it; then the 55-step serial normalizing
// divide and the bias add follow (the divide is skipped when the membership
// sum is zero), and a closing sample also loads the output register. The
// rule store is a single port-per-direction memory read one rule per access.
// o_in_stall is high while a sample is in work. A result held by
// i_out_stall does not block further requests until the next result is due.
// Reset (synchronous, active low) clears rule counts, biases, the vector
// sum, global bias and output valid; rule contents stay unknown until written.
// global_bias sits at APB address 0; pready is always high.
`default_nettype none
module fuzzy_ts_univariate_sum_inference_unit (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire  [1:0]            i_op,
    input  wire  [2:0]            i_var_index,
    input  wire  [3:0]            i_rule_index,
    input  wire  signed [31:0]    i_left_foot,
    input  wire  signed [31:0]    i_peak,
    input  wire  signed [31:0]    i_right_foot,
    input  wire  signed [31:0]    i_consequent,
    input  wire  [4:0]            i_rule_count,
    input  wire  signed [31:0]    i_var_bias,
    input  wire  signed [31:0]    i_sample,
    input  wire                   i_last_var,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output logic signed [31:0]    o_estimate,
    output logic                  o_saturated,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [1:0]            paddr,
    input  wire  [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import ftsi_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_NEXT, S_MEMB, S_MDIV, S_MUL, S_ACC, S_QDIV, S_SUM, S_EMIT
    } t_state;

    localparam logic signed [ACC_W:0] ACC_MAX = {2'b00, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W:0] ACC_MIN = {2'b11, {(ACC_W-1){1'b0}}};
    localparam logic signed [ACC_W:0] OUT_MAX = (ACC_W+1)'(64'sh7FFFFFFF);
    localparam logic signed [ACC_W:0] OUT_MIN = -(ACC_W+1)'(64'sh80000000);

    t_state                    r_state;
    logic signed [VAL_W-1:0]   r_gbias;
    logic [CNT_W-1:0]          r_cnt_tab [MAX_VARS];
    logic signed [VAL_W-1:0]   r_bias_tab [MAX_VARS];
    logic signed [ACC_W-1:0]   r_acc;

    logic [VAR_W-1:0]          r_var;
    logic signed [VAL_W-1:0]   r_x;
    logic [CNT_W-1:0]          r_n;
    logic [CNT_W-1:0]          r_idx;
    logic signed [VAL_W-1:0]   r_bias;
    logic                      r_last;
    logic [VAL_W:0]            r_den;
    logic [VAL_W+1:0]          r_mrem;
    logic [MU_W-1:0]           r_mu;
    logic signed [VAL_W-1:0]   r_theta;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [WSUM_W-1:0]  r_wsum;
    logic [MSUM_W-1:0]         r_msum;
    logic [5:0]                r_step;
    logic [WSUM_W-1:0]         r_qsh;
    logic [MSUM_W:0]           r_qrem;
    logic                      r_qneg;
    logic                      r_out_valid;
    logic signed [VAL_W-1:0]   r_estimate;
    logic                      r_saturated;

    // rule store
    logic                      mem_we;
    t_rule                     mem_wdata;
    t_rule                     mem_q;
    logic [RADDR_W-1:0]        mem_waddr;
    logic [RADDR_W-1:0]        mem_raddr;
    logic                      in_acc;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign mem_we    = in_acc && (i_op == OP_WRITE_RULE);
    assign mem_waddr = {i_var_index, i_rule_index};
    assign mem_raddr = {r_var, r_idx[RULE_W-1:0]};
    assign mem_wdata = '{left: i_left_foot, peak: i_peak, right: i_right_foot,
                         theta: i_consequent};

    ftsi_rule_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    // membership case selection on the rule just read
    logic signed [VAL_W:0] x33, a33, b33, c33;
    logic                  rise, fall;
    logic [VAL_W:0]        m_d, m_den;
    assign x33 = {r_x[VAL_W-1], r_x};
    assign a33 = {mem_q.left[VAL_W-1], mem_q.left};
    assign b33 = {mem_q.peak[VAL_W-1], mem_q.peak};
    assign c33 = {mem_q.right[VAL_W-1], mem_q.right};
    assign rise = (x33 > a33) && (x33 < b33);
    assign fall = (x33 >= b33) && (x33 < c33);
    always_comb begin
        if (rise) begin
            m_d   = VAL_W'(0) + (x33 - a33);
            m_den = b33 - a33;
        end else begin
            m_d   = c33 - x33;
            m_den = c33 - b33;
        end
    end

    // membership divide step
    logic [VAL_W+1:0] md_t;
    logic             md_ge;
    assign md_t  = {r_mrem[VAL_W:0], 1'b0};
    assign md_ge = md_t >= {1'b0, r_den};

    // normalizing divide step
    logic [MSUM_W:0] qd_t;
    logic            qd_ge;
    assign qd_t  = {r_qrem[MSUM_W-1:0], r_qsh[WSUM_W-1]};
    assign qd_ge = qd_t >= {1'b0, r_msum};

    // variable contribution and saturated accumulate
    logic signed [VAL_W:0]   q33;
    logic signed [VAL_W+1:0] y34;
    logic signed [ACC_W:0]   s49;
    logic signed [ACC_W:0]   t49;
    assign q33 = r_qneg ? -$signed(r_qsh[VAL_W:0]) : $signed(r_qsh[VAL_W:0]);
    assign y34 = {q33[VAL_W], q33} - {{2{r_bias[VAL_W-1]}}, r_bias};
    assign s49 = {r_acc[ACC_W-1], r_acc} + {{(ACC_W-VAL_W-1){y34[VAL_W+1]}}, y34};
    assign t49 = {r_acc[ACC_W-1], r_acc} + {{(ACC_W+1-VAL_W){r_gbias[VAL_W-1]}}, r_gbias};

    logic [WSUM_W-1:0] wabs;
    assign wabs = r_wsum[WSUM_W-1] ? WSUM_W'(-r_wsum) : WSUM_W'(r_wsum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gbias     <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_VARS; i++) begin
                r_cnt_tab[i]  <= '0;
                r_bias_tab[i] <= '0;
            end
        end else begin
            if (psel && penable && pwrite && paddr == ADDR_GLOBAL_BIAS) begin
                r_gbias <= pwdata;
            end
            if (r_out_valid && !i_out_stall && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_op == OP_SET_VAR) begin
                        r_cnt_tab[i_var_index]  <= (i_rule_count > CNT_W'(MAX_RULES))
                                                   ? CNT_W'(MAX_RULES) : i_rule_count;
                        r_bias_tab[i_var_index] <= i_var_bias;
                    end
                    if (in_acc && i_op == OP_SAMPLE) begin
                        r_var   <= i_var_index;
                        r_x     <= i_sample;
                        r_n     <= r_cnt_tab[i_var_index];
                        r_bias  <= r_bias_tab[i_var_index];
                        r_last  <= i_last_var;
                        r_idx   <= '0;
                        r_wsum  <= '0;
                        r_msum  <= '0;
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_idx == r_n) begin
                        r_qsh  <= (r_msum == '0) ? '0 : wabs;
                        r_qneg <= r_wsum[WSUM_W-1];
                        r_qrem <= '0;
                        r_step <= '0;
                        r_state <= (r_msum == '0) ? S_SUM : S_QDIV;
                    end else begin
                        r_state <= S_MEMB;
                    end
                end
                S_MEMB: begin
                    r_theta <= mem_q.theta;
                    r_den   <= m_den;
                    r_step  <= '0;
                    if (rise || fall) begin
                        r_mu    <= MU_W'(m_d >= m_den);
                        r_mrem  <= (VAL_W+2)'((m_d >= m_den) ? m_d - m_den : m_d);
                        r_state <= S_MDIV;
                    end else begin
                        r_mu    <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MDIV: begin
                    r_mrem <= md_ge ? md_t - {1'b0, r_den} : md_t;
                    r_mu   <= {r_mu[MU_W-2:0], md_ge};
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'(FRAC_BITS - 1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= $signed({1'b0, r_mu}) * r_theta;
                    r_msum  <= r_msum + MSUM_W'(r_mu);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_wsum  <= r_wsum + WSUM_W'(r_prod);
                    r_idx   <= r_idx + CNT_W'(1);
                    r_state <= S_NEXT;
                end
                S_QDIV: begin
                    r_qrem <= qd_ge ? qd_t - {1'b0, r_msum} : qd_t;
                    r_qsh  <= {r_qsh[WSUM_W-2:0], qd_ge};
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'(WSUM_W - 1)) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (s49 > ACC_MAX) begin
                        r_acc <= ACC_MAX[ACC_W-1:0];
                    end else if (s49 < ACC_MIN) begin
                        r_acc <= ACC_MIN[ACC_W-1:0];
                    end else begin
                        r_acc <= s49[ACC_W-1:0];
                    end
                    r_state <= r_last ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_acc       <= '0;
                        r_state     <= S_IDLE;
                        if (t49 > OUT_MAX) begin
                            r_estimate  <= OUT_MAX[VAL_W-1:0];
                            r_saturated <= 1'b1;
                        end else if (t49 < OUT_MIN) begin
                            r_estimate  <= OUT_MIN[VAL_W-1:0];
                            r_saturated <= 1'b1;
                        end else begin
                            r_estimate  <= t49[VAL_W-1:0];
                            r_saturated <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_estimate  = r_estimate;
    assign o_saturated = r_saturated;
    assign prdata      = (paddr == ADDR_GLOBAL_BIAS) ? r_gbias : '0;
    assign pready      = 1'b1;

    // a new result only comes out of the emit state
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result raised outside emit");

    // membership never exceeds one
    a_mu_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_mu <= MU_W'(1 << FRAC_BITS)))
        else $error("membership out of range");

    // rule store is never written while a sample walks it
    a_no_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_IDLE))
        else $error("rule write during sample");

endmodule
`default_nettype wire

// ===== sim/tb_fuzzy_ts_univariate_sum_inference_unit.sv =====
`timescale 1ns / 1ps
module tb_fuzzy_ts_univariate_sum_inference_unit;
    import ftsi_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int WORST_SAMPLE_CYC = MAX_RULES * 20 + 60;
    localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_LO = -ACC_HI - 1;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    logic [1:0] i_op;
    logic [2:0] i_var_index;
    logic [3:0] i_rule_index;
    logic signed [31:0] i_left_foot, i_peak, i_right_foot, i_consequent;
    logic [4:0] i_rule_count;
    logic signed [31:0] i_var_bias, i_sample;
    logic i_last_var;
    logic o_out_valid;
    logic i_out_stall;
    logic signed [31:0] o_estimate;
    logic o_saturated;
    logic psel, penable, pwrite;
    logic [1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;

    fuzzy_ts_univariate_sum_inference_unit dut (.*);

    always begin
        i_clk = 1'b0; #6;
        i_clk = 1'b1; #6;
    end

    // model state
    logic signed [31:0] m_left [MAX_VARS*MAX_RULES];
    logic signed [31:0] m_peak [MAX_VARS*MAX_RULES];
    logic signed [31:0] m_right[MAX_VARS*MAX_RULES];
    logic signed [31:0] m_theta[MAX_VARS*MAX_RULES];
    bit written[MAX_VARS*MAX_RULES];
    int unsigned m_count[MAX_VARS];
    logic signed [31:0] m_vbias[MAX_VARS];
    longint m_acc;
    logic signed [31:0] m_gbias;

    typedef struct {
        logic signed [31:0] estimate;
        logic saturated;
    } t_estimate;
    t_estimate pending_estimates[$];

    int errors;
    int items_sent;
    int results_seen;
    int sat_seen;
    bit stall_mode;

    // triangular membership, exact in 64 bits
    function automatic longint tri_mu(longint x, longint a, longint b, longint c);
        if (x > a && x < b) return ((x - a) <<< FRAC_BITS) / (b - a);
        if (x >= b && x < c) return ((c - x) <<< FRAC_BITS) / (c - b);
        return 0;
    endfunction

    // weighted mean of one variable's rules; 128-bit weighted sum
    function automatic longint var_mean(int v, longint x);
        logic signed [127:0] wsum;
        longint msum, mu;
        int s;
        wsum = 0;
        msum = 0;
        for (int i = 0; i < m_count[v]; i++) begin
            s = v * MAX_RULES + i;
            mu = tri_mu(x, m_left[s], m_peak[s], m_right[s]);
            msum += mu;
            wsum += 128'(mu) * 128'(signed'(m_theta[s]));
        end
        if (msum == 0) return 0;
        return longint'(wsum / 128'(msum));
    endfunction

    task automatic predict_request(logic [1:0] op, int v, int r, logic signed [31:0] a,
                                   logic signed [31:0] b, logic signed [31:0] c,
                                   logic signed [31:0] th, int cnt,
                                   logic signed [31:0] vb, logic signed [31:0] x,
                                   bit last);
        longint y, total;
        t_estimate e;
        case (op)
            OP_WRITE_RULE: begin
                m_left[v*MAX_RULES+r] = a;
                m_peak[v*MAX_RULES+r] = b;
                m_right[v*MAX_RULES+r] = c;
                m_theta[v*MAX_RULES+r] = th;
                written[v*MAX_RULES+r] = 1'b1;
            end
            OP_SET_VAR: begin
                m_count[v] = (cnt > MAX_RULES) ? MAX_RULES : cnt;
                m_vbias[v] = vb;
            end
            OP_SAMPLE: begin
                y = var_mean(v, x) - longint'(m_vbias[v]);
                m_acc = m_acc + y;
                if (m_acc > ACC_HI) m_acc = ACC_HI;
                if (m_acc < ACC_LO) m_acc = ACC_LO;
                if (last) begin
                    total = m_acc + longint'(m_gbias);
                    e.saturated = 1'b0;
                    if (total > 64'sd2147483647) begin
                        total = 64'sd2147483647;
                        e.saturated = 1'b1;
                    end else if (total < -64'sd2147483648) begin
                        total = -64'sd2147483648;
                        e.saturated = 1'b1;
                    end
                    e.estimate = total[31:0];
                    pending_estimates.push_back(e);
                    m_acc = 0;
                end
            end
            default: ;
        endcase
    endtask

    // send one request, with an occasional random gap first; valid stays up afterwards
    task automatic send_request(logic [1:0] op, int v, int r, logic signed [31:0] a,
                                logic signed [31:0] b, logic signed [31:0] c,
                                logic signed [31:0] th, int cnt,
                                logic signed [31:0] vb, logic signed [31:0] x,
                                bit last, bit gaps = 1);
        if (gaps && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_var_index <= 3'(v);
        i_rule_index <= 4'(r);
        i_left_foot <= a;
        i_peak <= b;
        i_right_foot <= c;
        i_consequent <= th;
        i_rule_count <= 5'(cnt);
        i_var_bias <= vb;
        i_sample <= x;
        i_last_var <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_request(op, v, r, a, b, c, th, cnt, vb, x, last);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_estimates.size() != 0) @(negedge i_clk);
        repeat (WORST_SAMPLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_global_bias(logic signed [31:0] val);
        i_in_valid <= 1'b0;
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_GLOBAL_BIAS; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        m_gbias = val;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(negedge i_clk);
        psel <= 1'b1; paddr <= ADDR_GLOBAL_BIAS;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== val) begin
            $error("global_bias readback expected %h actual %h", val, prdata);
            errors++;
        end
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $urandom;
            default: return $signed($urandom_range(0, 32'h0014_0000)) - 32'sh000A_0000;
        endcase
    endfunction

    // random rule: mostly well-formed a < b < c near the sample range
    task automatic rand_rule(int v, int r);
        logic signed [31:0] a, b, c;
        if ($urandom_range(0, 9) < 8) begin
            b = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            a = b - $signed($urandom_range(1, 32'h0006_0000));
            c = b + $signed($urandom_range(1, 32'h0006_0000));
        end else begin
            a = rand_val(); b = rand_val(); c = rand_val();
        end
        send_request(OP_WRITE_RULE, v, r, a, b, c, rand_val(), 0, 0, 0, 0);
    endtask

    // sample only variables whose used rules are all written
    function automatic bit var_ready(int v);
        for (int i = 0; i < m_count[v]; i++)
            if (!written[v*MAX_RULES+i]) return 0;
        return 1;
    endfunction

    task automatic rand_sample(bit last);
        int v;
        v = $urandom_range(0, MAX_VARS - 1);
        if (!var_ready(v)) v = 7;
        if (!var_ready(v)) begin
            send_request(OP_SET_VAR, v, 0, 0, 0, 0, 0, 0, rand_val(), 0, 0);
            v = 7;
        end
        send_request(OP_SAMPLE, v, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom,
                     $signed($urandom_range(0, 32'h0014_0000)) - 32'sh000A_0000, last);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_estimate e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_estimates.size() == 0) begin
                $error("estimate with none expected: %h", o_estimate);
                errors++;
            end else begin
                e = pending_estimates.pop_front();
                if (o_saturated) sat_seen++;
                if (o_estimate !== e.estimate) begin
                    $error("estimate expected %h actual %h", e.estimate, o_estimate);
                    errors++;
                end
                if (o_saturated !== e.saturated) begin
                    $error("saturated expected %b actual %b", e.saturated, o_saturated);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (stall_mode) i_out_stall <= ($urandom_range(0, 2) == 0);
        else i_out_stall <= 1'b0;
    end

    task automatic test_directed();
        send_request(OP_WRITE_RULE, 0, 0, -32'sh0001_0000, 0, 32'sh0001_0000,
                     32'sh0002_0000, 0, 0, 0, 0);
        send_request(OP_WRITE_RULE, 0, 15, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                     32'sh7FFF_FFFF, 0, 0, 0, 0);
        send_request(OP_WRITE_RULE, 0, 1, 32'sh0003_0000, 32'sh0001_0000, 0,
                     32'sh8000_0000, 0, 0, 0, 0);
        for (int r = 2; r < 15; r++)
            send_request(OP_WRITE_RULE, 0, r, r, r, r, r, 0, 0, 0, 0);
        send_request(OP_SET_VAR, 0, 0, 0, 0, 0, 0, 31, 32'sh0000_8000, 0, 0);
        send_request(OP_SET_VAR, 1, 0, 0, 0, 0, 0, 0, 32'sh8000_0000, 0, 0);
        send_request(OP_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
        // partial membership, zero-sum variable, the peak itself and the most negative sample
        send_request(OP_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, -32'sh0000_8000, 0);
        send_request(OP_SAMPLE, 1, 0, 0, 0, 0, 0, 0, 0, 32'sh7FFF_FFFF, 1);
        send_request(OP_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
        send_request(OP_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, 32'sh8000_0000, 1);
        // output clipping: several -var_bias = +2^31 contributions
        for (int k = 0; k < 3; k++)
            send_request(OP_SAMPLE, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_request(OP_SAMPLE, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1);
        wait_drained();
    endtask

    task automatic test_global_bias(logic signed [31:0] gb, int vectors);
        write_global_bias(gb);
        for (int n = 0; n < vectors; n++) begin
            for (int k = $urandom_range(0, 3); k > 0; k--) rand_sample(0);
            rand_sample(1);
        end
        wait_drained();
    endtask

    task automatic test_random(int count);
        int v;
        while (count > 0) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    rand_rule($urandom_range(0, MAX_VARS - 1), $urandom_range(0, 15));
                end
                2: begin
                    v = $urandom_range(0, MAX_VARS - 1);
                    send_request(OP_SET_VAR, v, 0, 0, 0, 0, 0, $urandom_range(0, 31),
                                 rand_val(), 0, 0);
                end
                3: send_request(OP_NONE, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom, $urandom, $urandom,
                                1'($urandom));
                default: rand_sample($urandom_range(0, 2) == 0);
            endcase
            count--;
            if (count % 200 == 0) stall_mode = ~stall_mode;
        end
        rand_sample(1);
        wait_drained();
    endtask

    initial begin
        errors = 0; items_sent = 0; results_seen = 0; sat_seen = 0;
        stall_mode = 1'b0;
        m_acc = 0; m_gbias = 0;
        for (int i = 0; i < MAX_VARS; i++) begin
            m_count[i] = 0; m_vbias[i] = 0;
        end
        for (int i = 0; i < MAX_VARS * MAX_RULES; i++) written[i] = 1'b0;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_out_stall = 1'b0;
        i_op = OP_NONE; i_var_index = 0; i_rule_index = 0;
        i_left_foot = 0; i_peak = 0; i_right_foot = 0; i_consequent = 0;
        i_rule_count = 0; i_var_bias = 0; i_sample = 0; i_last_var = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = ADDR_GLOBAL_BIAS; pwdata = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        stall_mode = 1'b1;
        // fill every variable so random samples reach real rule bases
        for (int v = 0; v < MAX_VARS; v++) begin
            for (int r = 0; r < MAX_RULES; r++) rand_rule(v, r);
            send_request(OP_SET_VAR, v, 0, 0, 0, 0, 0, $urandom_range(1, 16),
                         rand_val(), 0, 0);
        end
        test_global_bias(32'sh7FFF_FFFF, 6);
        test_global_bias(32'sh8000_0000, 6);
        test_random(1320);
        test_global_bias($urandom, 10);
        test_global_bias(0, 5);

        $display("Sent %0d requests, checked %0d estimates (%0d saturated).",
                 items_sent, results_seen, sat_seen);
        if (errors == 0 && pending_estimates.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #40ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
